// File: hdl/scpwm_pkg.sv
package scpwm_pkg;

    localparam int DEFAULT_CHANNELS    = 6;
    localparam int DEFAULT_COUNT_WIDTH = 32;
    localparam int LEVEL_WIDTH         = 6;
    localparam int CHANNEL_WIDTH       = 3;
    localparam int DUTY_WIDTH          = 32;
    localparam int CFG_DATA_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH     = 2;

    typedef enum logic
    {
        CMD_TICK = 1'b0,
        CMD_DUTY = 1'b1
    } command_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0]
    {
        REG_PRESCALE       = 2'd0,
        REG_PERIOD_TOP     = 2'd1,
        REG_CHANNEL_ENABLE = 2'd2
    } cfg_reg_t;

    typedef struct packed
    {
        command_t                 command;
        logic [CHANNEL_WIDTH-1:0] channel;
        logic [DUTY_WIDTH-1:0]    duty;
    } item_t;

    typedef struct packed
    {
        logic [LEVEL_WIDTH-1:0] pwm_levels;
        logic                   period_wrap;
    } result_t;

endpackage

// File: hdl/six_channel_pwm_generator_top.sv
// Six-channel single-edge PWM timer with shadowed match registers.
// The item channel (item_valid, item_stall, item) carries either a timer tick
// or a duty write to one channel's shadow match register. Every accepted beat
// yields exactly one beat on the result channel (result_valid, result_stall,
// result) with the channel levels after that beat and a flag that marks the
// tick which wrapped the period counter and loaded the pending shadows.
// An accepted beat passes through the input register and then the result
// register, where it is shown; a stall on the result side can hold it in
// either register. One beat is taken in every cycle while the result side
// does not stall.
// The path is an input register and a result register with the counter,
// shadow load and compare logic between them.
// When result_stall is high with a result waiting, the result holds, the
// input register keeps its beat and item_stall rises until the result moves.
// The user writes registers via cfg_write_en, cfg_index and cfg_data only while
// the block is idle (not enforced); they act at once and leave counters alone.
// Reset clears the counters, the configuration, both sets of match registers
// and the pending flags, and empties both registers of the path.
module six_channel_pwm_generator_top
#(
    parameter int CHANNELS    = scpwm_pkg::DEFAULT_CHANNELS,
    parameter int COUNT_WIDTH = scpwm_pkg::DEFAULT_COUNT_WIDTH
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [scpwm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [scpwm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  scpwm_pkg::item_t                      item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output scpwm_pkg::result_t                    result
);

    localparam int VISIBLE = (CHANNELS < scpwm_pkg::LEVEL_WIDTH) ?
                             CHANNELS : scpwm_pkg::LEVEL_WIDTH;

    logic [COUNT_WIDTH-1:0]             prescale_reg;
    logic [COUNT_WIDTH-1:0]             period_top_reg;
    logic [scpwm_pkg::LEVEL_WIDTH-1:0]  channel_enable_reg;

    logic [COUNT_WIDTH-1:0]             prescale_count_reg;
    logic [COUNT_WIDTH-1:0]             prescale_count_next;
    logic [COUNT_WIDTH-1:0]             period_count_reg;
    logic [COUNT_WIDTH-1:0]             period_count_next;
    logic [COUNT_WIDTH-1:0]             shadow_match_reg [CHANNELS];
    logic [COUNT_WIDTH-1:0]             shadow_match_next [CHANNELS];
    logic [COUNT_WIDTH-1:0]             active_match_reg [CHANNELS];
    logic [COUNT_WIDTH-1:0]             active_match_next [CHANNELS];
    logic [CHANNELS-1:0]                load_pending_reg;
    logic [CHANNELS-1:0]                load_pending_next;

    logic                               item_valid_reg;
    scpwm_pkg::item_t                   item_reg;
    logic                               result_valid_reg;
    scpwm_pkg::result_t                 result_reg;
    scpwm_pkg::result_t                 result_next;

    logic                               advance;
    logic                               fire;
    logic                               wrapped;
    logic [scpwm_pkg::LEVEL_WIDTH-1:0]  levels;

    assign advance      = !result_valid_reg || !result_stall;
    assign fire         = item_valid_reg && advance;
    assign item_stall   = item_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg       <= '0;
            period_top_reg     <= '0;
            channel_enable_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (scpwm_pkg::cfg_reg_t'(cfg_index))
                scpwm_pkg::REG_PRESCALE:
                begin
                    prescale_reg <= cfg_data[COUNT_WIDTH-1:0];
                end
                scpwm_pkg::REG_PERIOD_TOP:
                begin
                    period_top_reg <= cfg_data[COUNT_WIDTH-1:0];
                end
                scpwm_pkg::REG_CHANNEL_ENABLE:
                begin
                    channel_enable_reg <= cfg_data[scpwm_pkg::LEVEL_WIDTH-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        period_count_next   = period_count_reg;
        shadow_match_next   = shadow_match_reg;
        active_match_next   = active_match_reg;
        load_pending_next   = load_pending_reg;
        wrapped             = 1'b0;

        if (fire)
        begin
            if (item_reg.command == scpwm_pkg::CMD_DUTY)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (item_reg.channel == scpwm_pkg::CHANNEL_WIDTH'(c))
                    begin
                        shadow_match_next[c] = item_reg.duty[COUNT_WIDTH-1:0];
                        load_pending_next[c] = 1'b1;
                    end
                end
            end
            else if (prescale_count_reg >= prescale_reg)
            begin
                prescale_count_next = '0;
                if (period_count_reg >= period_top_reg)
                begin
                    period_count_next = '0;
                    wrapped           = 1'b1;
                    load_pending_next = '0;
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (load_pending_reg[c])
                        begin
                            active_match_next[c] = shadow_match_reg[c];
                        end
                    end
                end
                else
                begin
                    period_count_next = period_count_reg + 1'b1;
                end
            end
            else
            begin
                prescale_count_next = prescale_count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        levels = '0;
        for (int c = 0; c < VISIBLE; c++)
        begin
            levels[c] = channel_enable_reg[c] && (period_count_next < active_match_next[c]);
        end
        result_next.pwm_levels  = levels;
        result_next.period_wrap = wrapped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            period_count_reg   <= '0;
            load_pending_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                shadow_match_reg[c] <= '0;
                active_match_reg[c] <= '0;
            end
        end
        else
        begin
            prescale_count_reg <= prescale_count_next;
            period_count_reg   <= period_count_next;
            load_pending_reg   <= load_pending_next;
            shadow_match_reg   <= shadow_match_next;
            active_match_reg   <= active_match_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule
